// File: design/lsrns_pkg.sv
package lsrns_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEAF_W       = $clog2(MAX_ELEMENTS);
  localparam int NODE_W       = LEAF_W + 1;
  localparam int LVL_W        = $clog2(LEAF_W + 1);
  localparam int VALUE_W      = 16;
  localparam int SUM_W        = VALUE_W + LEAF_W + 1;
  localparam int OUT_W        = 26;
  localparam int CNT_W        = 11;
  localparam int CMDQ_DEPTH   = 2;  // power of two

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_ELEMENTS);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(2**(OUT_W-1) - 1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(2**(OUT_W-1)));

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FLIP  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FLIP,
    CMD_QUERY,
    CMD_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [LEAF_W-1:0]        lo;
    logic [LEAF_W-1:0]        hi;
    logic signed [SUM_W-1:0]  value;
  } cmd_t;

  // one entry per internal node p: both child sums and both child flip tags
  typedef struct packed {
    logic [1:0]            f;
    logic [1:0][SUM_W-1:0] x;
  } entry_t;

  typedef logic [LVL_W-1:0] lvl_t;

  // ancestor of a leaf at a given level (root is level 0)
  function automatic logic [NODE_W-1:0] path_node(input logic [LEAF_W-1:0] leaf,
                                                  input lvl_t lvl);
    lvl_t sh;
    sh = LVL_W'(LEAF_W) - lvl;
    return {1'b1, leaf} >> sh;
  endfunction

  function automatic logic [LEAF_W-1:0] span_lo(input logic [NODE_W-1:0] node,
                                                input lvl_t lvl);
    logic [NODE_W-1:0] t;
    lvl_t sh;
    sh = LVL_W'(LEAF_W) - lvl;
    t  = node << sh;
    return t[LEAF_W-1:0];
  endfunction

  function automatic logic covered(input logic [NODE_W-1:0] node, input lvl_t lvl,
                                   input logic [LEAF_W-1:0] a,
                                   input logic [LEAF_W-1:0] b);
    logic [LEAF_W-1:0] lo;
    logic [LEAF_W-1:0] hi;
    lo = span_lo(node, lvl);
    hi = lo | ({LEAF_W{1'b1}} >> lvl);
    return (a <= lo) && (hi <= b);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
    logic signed [OUT_W-1:0] r;
    if (s > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (s < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = s[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/lazy_segment_tree_range_negate_sum.sv
// channel   direction  handshake                 payload
// cmd       in         start && !busy            op, range_low, range_high, element_value
// result    out        done (one cycle, no stall) range_sum
// config    in         cfg_wr                    cfg_wdata (element_count)
//
// Items pass through a two-entry queue to a tree walker over a two-read-port node RAM.
// Query: from the queue head, a pop, ten levels read in a pipeline, then a drain.
// Load or negate: a walk down, then two write-backs per level on one port.
// Empty-range query and whole-array negate or query finish in the idle state, with no tree walk.
// Reset and every element_count write start a clear of every RAM entry; busy is high meanwhile.
// The result side cannot stall; busy rises only when the queue is full or the RAM is clearing.
module lazy_segment_tree_range_negate_sum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           op,
  input  logic [lsrns_pkg::LEAF_W-1:0]         range_low,
  input  logic [lsrns_pkg::LEAF_W-1:0]         range_high,
  input  logic signed [lsrns_pkg::VALUE_W-1:0] element_value,
  input  logic                                 cfg_wr,
  input  logic [lsrns_pkg::CNT_W-1:0]          cfg_wdata,
  output logic                                 done,
  output logic signed [lsrns_pkg::OUT_W-1:0]   range_sum
);
  import lsrns_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  logic clr_req;
  logic back_clearing;
  cmd_t push_cmd;
  cmd_t q_head;

  lsrns_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .range_low     (range_low),
    .range_high    (range_high),
    .element_value (element_value),
    .cfg_wr        (cfg_wr),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .back_clearing (back_clearing),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd),
    .clr_req       (clr_req)
  );

  lsrns_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  lsrns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clr_req   (clr_req),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .clearing  (back_clearing),
    .done      (done),
    .range_sum (range_sum)
  );

endmodule

// File: design/lsrns_front.sv
module lsrns_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          op,
  input  logic [lsrns_pkg::LEAF_W-1:0]        range_low,
  input  logic [lsrns_pkg::LEAF_W-1:0]        range_high,
  input  logic signed [lsrns_pkg::VALUE_W-1:0] element_value,
  input  logic                                cfg_wr,
  input  logic [lsrns_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                                q_full,
  input  logic                                back_clearing,
  output logic                                busy,
  output logic                                push,
  output lsrns_pkg::cmd_t                     push_cmd,
  output logic                                clr_req
);
  import lsrns_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] n_eff;
  logic             load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
    end else if (cfg_wr) begin
      element_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (element_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (element_count > CNT_W'(MAX_ELEMENTS)) begin
      n_eff = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_eff = element_count;
    end
  end

  // elements at or above the count (a count of zero acts as one) are never loaded
  // and so stay zero; ranges need no clipping
  assign load_ok = CNT_W'(range_low) < n_eff;
  assign busy    = q_full | back_clearing;
  assign clr_req = cfg_wr;

  always_comb begin
    push           = 1'b0;
    push_cmd.kind  = CMD_ZERO;
    push_cmd.lo    = range_low;
    push_cmd.hi    = range_high;
    push_cmd.value = SUM_W'(element_value);
    if (start && !busy) begin
      unique case (op_t'(op))
        OP_LOAD: begin
          push          = load_ok;
          push_cmd.kind = CMD_LOAD;
          push_cmd.hi   = range_low;
        end
        OP_FLIP: begin
          push          = range_low <= range_high;
          push_cmd.kind = CMD_FLIP;
        end
        OP_QUERY: begin
          push          = 1'b1;
          push_cmd.kind = (range_low <= range_high) ? CMD_QUERY : CMD_ZERO;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/lsrns_cmd_fifo.sv
module lsrns_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lsrns_pkg::cmd_t push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output lsrns_pkg::cmd_t head
);
  import lsrns_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W+1)'(CMDQ_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
    end
  end

endmodule

// File: design/lsrns_back.sv
module lsrns_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clr_req,
  input  logic                              q_empty,
  input  lsrns_pkg::cmd_t                   q_head,
  output logic                              pop,
  output logic                              clearing,
  output logic                              done,
  output logic signed [lsrns_pkg::OUT_W-1:0] range_sum
);
  import lsrns_pkg::*;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int ENTRIES = MAX_ELEMENTS;  // internal nodes 1..MAX-1, slot 0 unused

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DOWN, S_UP} state_t;

  typedef struct packed {
    entry_t l;
    entry_t r;
  } pair_t;

  typedef struct packed {
    entry_t                  e;
    logic signed [SUM_W-1:0] add;
  } slot_res_t;

  state_t                  state;
  cmd_t                    cmd;
  lvl_t                    cnt;
  logic                    ph;
  logic [LEAF_W-1:0]       clr_idx;
  logic                    ql;
  logic                    qr;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] root_sum;
  logic                    root_tag;
  pair_t                   stk [LEAF_W];

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRY_W-1:0] rd_l;
  logic [ENTRY_W-1:0] rd_r;
  logic               we;
  logic [LEAF_W-1:0]  wa;
  logic [ENTRY_W-1:0] wd;
  logic [LEAF_W-1:0]  ra_l;
  logic [LEAF_W-1:0]  ra_r;

  // walk-down decode
  lvl_t                    pk;
  logic [NODE_W-1:0]       nl;
  logic [NODE_W-1:0]       nr;
  logic [NODE_W-1:0]       nl_n;
  logic [NODE_W-1:0]       nr_n;
  logic                    vl;
  logic                    vr;
  entry_t                  el;
  entry_t                  er;
  slot_res_t               sl;
  slot_res_t               sr;
  logic                    ql_next;
  logic                    qr_next;
  logic signed [SUM_W-1:0] acc_next;

  // walk-up decode
  logic [NODE_W-1:0]       pl;
  logic [NODE_W-1:0]       pr;
  logic signed [SUM_W-1:0] raw_l;
  logic signed [SUM_W-1:0] raw_r;
  pair_t                   top;
  pair_t                   patched;
  logic                    root_hit;

  function automatic slot_res_t apply_slot(input entry_t e, input logic q,
                                           input logic [NODE_W-1:0] node,
                                           input lvl_t lvl, input cmd_t c);
    slot_res_t               r;
    logic [NODE_W-1:0]       child;
    logic signed [SUM_W-1:0] x;
    lvl_t                    cl;
    r     = '{e: e, add: '0};
    cl    = lvl + 1'b1;
    for (int i = 0; i < 2; i++) begin
      child = {node[NODE_W-2:0], i[0]};
      x     = e.x[i];
      if (covered(child, cl, c.lo, c.hi)) begin
        case (c.kind)
          CMD_QUERY: r.add = r.add + (q ? -x : x);
          CMD_FLIP: begin
            r.e.x[i] = -x;
            r.e.f[i] = ~e.f[i];
          end
          CMD_LOAD:  r.e.x[i] = q ? -c.value : c.value;
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_l <= mem[ra_l];
    rd_r <= mem[ra_r];
  end

  // q tracks the tag parity above a path node's children
  always_comb begin
    pk       = cnt - 1'b1;
    nl       = path_node(cmd.lo, pk);
    nr       = path_node(cmd.hi, pk);
    vl       = !covered(nl, pk, cmd.lo, cmd.hi);
    vr       = !covered(nr, pk, cmd.lo, cmd.hi) && (nr != nl);
    el       = entry_t'(rd_l);
    er       = entry_t'(rd_r);
    sl       = apply_slot(el, ql, nl, pk, cmd);
    sr       = apply_slot(er, qr, nr, pk, cmd);
    nl_n     = path_node(cmd.lo, cnt);
    nr_n     = path_node(cmd.hi, cnt);
    ql_next  = ql ^ el.f[nl_n[0]];
    qr_next  = (nr == nl) ? (ql ^ el.f[nr_n[0]]) : (qr ^ er.f[nr_n[0]]);
    acc_next = acc + (vl ? sl.add : '0) + (vr ? sr.add : '0);
    ra_l     = nl_n[LEAF_W-1:0];
    ra_r     = nr_n[LEAF_W-1:0];
  end

  // walking up, cnt is the level being written back; its sums patch the level above
  always_comb begin
    top     = stk[0];
    raw_l   = $signed(top.l.x[0]) + $signed(top.l.x[1]);
    raw_r   = $signed(top.r.x[0]) + $signed(top.r.x[1]);
    pl      = path_node(cmd.lo, pk);
    pr      = path_node(cmd.hi, pk);
    patched = stk[1];
    if (!covered(nl_n, cnt, cmd.lo, cmd.hi)) begin
      patched.l.x[nl_n[0]] = stk[1].l.f[nl_n[0]] ? -raw_l : raw_l;
    end
    if (!covered(nr_n, cnt, cmd.lo, cmd.hi) && (nr_n != nl_n)) begin
      if (pr == pl) begin
        patched.l.x[nr_n[0]] = stk[1].l.f[nr_n[0]] ? -raw_r : raw_r;
      end else begin
        patched.r.x[nr_n[0]] = stk[1].r.f[nr_n[0]] ? -raw_r : raw_r;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = nl_n[LEAF_W-1:0];
    wd = top.l;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = clr_idx;
      wd = '0;
    end else if (state == S_UP) begin
      if (!ph) begin
        we = !covered(nl_n, cnt, cmd.lo, cmd.hi);
      end else begin
        we = !covered(nr_n, cnt, cmd.lo, cmd.hi) && (nr_n != nl_n);
        wa = nr_n[LEAF_W-1:0];
        wd = top.r;
      end
    end
  end

  assign root_hit = (q_head.lo == '0) && (q_head.hi == '1) && (q_head.kind != CMD_LOAD);
  assign pop      = (state == S_IDLE) && !q_empty && !clr_req;
  assign clearing = state == S_CLEAR;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || clr_req) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      root_sum <= '0;
      root_tag <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LEAF_W'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd <= q_head;
            if (q_head.kind == CMD_ZERO) begin
              done      <= 1'b1;
              range_sum <= '0;
            end else if (root_hit) begin
              if (q_head.kind == CMD_QUERY) begin
                done      <= 1'b1;
                range_sum <= sat_sum(root_sum);
              end else begin
                root_sum <= -root_sum;
                root_tag <= ~root_tag;
              end
            end else begin
              state <= S_DOWN;
              cnt   <= '0;
              ql    <= root_tag;
              qr    <= root_tag;
              acc   <= '0;
            end
          end
        end
        S_DOWN: begin
          if (cnt != '0) begin
            acc    <= acc_next;
            ql     <= ql_next;
            qr     <= qr_next;
            stk[0] <= '{l: sl.e, r: sr.e};
            for (int i = 1; i < LEAF_W; i++) begin
              stk[i] <= stk[i-1];
            end
          end
          if (cnt == LVL_W'(LEAF_W)) begin
            if (cmd.kind == CMD_QUERY) begin
              done      <= 1'b1;
              range_sum <= sat_sum(acc_next);
              state     <= S_IDLE;
            end else begin
              state <= S_UP;
              cnt   <= LVL_W'(LEAF_W - 1);
              ph    <= 1'b0;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_UP: begin
          ph <= ~ph;
          if (ph) begin
            stk[0] <= patched;
            for (int i = 1; i < LEAF_W - 1; i++) begin
              stk[i] <= stk[i+1];
            end
            if (cnt == '0) begin
              root_sum <= root_tag ? -raw_l : raw_l;
              state    <= S_IDLE;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: design/lsrns_checker.sv
module lsrns_checker (
  input logic clk,
  input logic rst,
  input logic cfg_wr,
  input logic busy,
  input logic done
);

  // reset starts the RAM clear and drops any result
  a_reset_clears: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("no clear after reset");

  // a count write restarts the clear at once
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy && !done)
    else $error("no clear after count write");

  // the clear does not end at once
  a_clear_long: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> ##1 busy)
    else $error("clear ended too early");

endmodule

bind lazy_segment_tree_range_negate_sum lsrns_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .cfg_wr (cfg_wr),
  .busy   (busy),
  .done   (done)
);
